@@ sv/qrs_pkg.sv @@
// ----------------------------------------------------------------------------
// qrs_pkg: shared types and constants of the quadratic root solver
// Payload structs, root kind codes, fixed-point widths and the state that
// travels along the square-root and divider cell chains.
// ----------------------------------------------------------------------------
`default_nettype none

package qrs_pkg;

	// Coefficient and root formats
	localparam int CW     = 16;            // coefficient width, Q8.8
	localparam int RW     = 32;            // root width, Q16.16
	localparam int CFR    = CW / 2;        // coefficient fraction bits
	localparam int RFR    = RW / 2;        // root fraction bits
	localparam int UP_SH  = RFR - CFR;     // coefficient to root scale

	// Discriminant
	localparam int PROD_W = 2 * CW;        // one coefficient product
	localparam int DISC_W = PROD_W + 3;    // b*b - 4*a*c, exact
	localparam int DMAG_W = DISC_W - 1;    // |disc|

	// Square root chain: one result bit per cell
	localparam int SQ_STEPS = (DMAG_W + 2 * UP_SH + 1) / 2;
	localparam int RAD_W    = 2 * SQ_STEPS;
	localparam int ROOT_W   = SQ_STEPS;
	localparam int SREM_W   = ROOT_W + 3;

	// Divider chain: one quotient bit per cell
	localparam int NUM_W  = 36;            // signed numerator
	localparam int NQ_W   = NUM_W - 1;     // numerator magnitude / quotient
	localparam int DEN_W  = CW + 1;        // divisor magnitude
	localparam int DREM_W = CW;            // partial remainder

	localparam logic [NQ_W-1:0] POS_LIM = NQ_W'((64'd1 << (RW - 1)) - 64'd1);
	localparam logic [NQ_W-1:0] NEG_LIM = NQ_W'(64'd1 << (RW - 1));

	typedef enum logic [2:0] {
		KIND_LINEAR     = 3'd0,
		KIND_EQUAL      = 3'd1,
		KIND_DISTINCT   = 3'd2,
		KIND_COMPLEX    = 3'd3,
		KIND_DEGENERATE = 3'd4
	} kind_t;

	typedef struct packed {
		logic signed [CW-1:0] coef_a;
		logic signed [CW-1:0] coef_b;
		logic signed [CW-1:0] coef_c;
	} coef_t;

	typedef struct packed {
		kind_t                root_kind;
		logic signed [RW-1:0] first_value;
		logic signed [RW-1:0] second_value;
		logic                 clipped;
	} root_t;

	// Side data carried along the square-root cells
	typedef struct packed {
		kind_t                kind;
		logic signed [CW-1:0] a;
		logic signed [CW-1:0] b;
		logic signed [CW-1:0] c;
	} sq_side_t;

	typedef struct packed {
		logic [RAD_W-1:0]  rad;
		logic [SREM_W-1:0] rem;
		logic [ROOT_W-1:0] root;
	} sq_state_t;

	// Divider cells: one lane per root word
	typedef struct packed {
		logic [DREM_W-1:0] rem;
		logic [NQ_W-1:0]   nq;
	} dv_lane_t;

	typedef dv_lane_t [1:0] dv_pair_t;

	typedef struct packed {
		kind_t            kind;
		logic [DEN_W-1:0] den_mag;
		logic [1:0]       neg;
	} dv_side_t;

endpackage

`default_nettype wire

@@ sv/qrs_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// qrs_sqrt_cell: one step of the digit-by-digit square root
// Brings down two radicand bits, tries the next root bit and registers the
// partial remainder, partial root and side data for the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_sqrt_cell (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              valid_in,
	input  wire qrs_pkg::sq_side_t side_in,
	input  wire qrs_pkg::sq_state_t st_in,
	output logic                   valid_q,
	output qrs_pkg::sq_side_t      side_q,
	output qrs_pkg::sq_state_t     st_q
);
	import qrs_pkg::*;

	logic [SREM_W-1:0] trial;
	logic [SREM_W-1:0] t;
	logic              ge;
	sq_state_t         nxt;

	always_comb begin
		t       = {st_in.rem[SREM_W-3:0], st_in.rad[RAD_W-1 -: 2]};
		trial   = {1'b0, st_in.root, 2'b01};
		ge      = (t >= trial);
		nxt.rad = {st_in.rad[RAD_W-3:0], 2'b00};
		nxt.rem = ge ? (t - trial) : t;
		nxt.root = {st_in.root[ROOT_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q <= side_in;
			st_q   <= nxt;
		end
	end

endmodule

`default_nettype wire

@@ sv/qrs_div_cell.sv @@
// ----------------------------------------------------------------------------
// qrs_div_cell: one step of restoring division on both root lanes
// Shifts one numerator bit into each partial remainder, subtracts the
// divisor where it fits and shifts the quotient bit in at the bottom.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_div_cell (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              valid_in,
	input  wire qrs_pkg::dv_side_t side_in,
	input  wire qrs_pkg::dv_pair_t pair_in,
	output logic                   valid_q,
	output qrs_pkg::dv_side_t      side_q,
	output qrs_pkg::dv_pair_t      pair_q
);
	import qrs_pkg::*;

	dv_pair_t nxt;

	always_comb begin
		logic [DEN_W-1:0] t;
		logic             ge;
		for (int k = 0; k < 2; k++) begin
			t  = {pair_in[k].rem, pair_in[k].nq[NQ_W-1]};
			ge = (t >= side_in.den_mag);
			nxt[k].rem = ge ? DREM_W'(t - side_in.den_mag) : t[DREM_W-1:0];
			nxt[k].nq  = {pair_in[k].nq[NQ_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q <= side_in;
			pair_q <= nxt;
		end
	end

endmodule

`default_nettype wire

@@ sv/quadratic_root_solver.sv @@
// ----------------------------------------------------------------------------
// quadratic_root_solver: roots of a*x^2 + b*x + c = 0
// Q8.8 coefficients in, Q16.16 roots out, with exact discriminant, floor
// square root, division truncated toward zero and saturation.
// ----------------------------------------------------------------------------
// Throughput: one coefficient beat per cycle while the pipeline is not frozen;
// every stage is a register. Depth is set by the 25-cell square root chain
// and the 35-cell divider chain. The pipeline freezes only when a result sits
// in the output register, the sink stalls and another result is ready behind
// it; bubbles never stall input. Reset clears all valid bits and the output
// valid; payload is not reset.
`default_nettype none

module quadratic_root_solver (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           coef_valid,
	output logic                coef_stall,
	input  wire qrs_pkg::coef_t coef,
	output logic                root_valid,
	input  wire logic           root_stall,
	output qrs_pkg::root_t      root
);
	import qrs_pkg::*;

	// Global advance: hold everything only when the last cell cannot drain
	logic en;
	logic last_valid;

	// ------------------------------------------------------------------
	// Stage 1: coefficient products
	// ------------------------------------------------------------------
	logic                     valid_s1;
	logic signed [CW-1:0]     a_s1, b_s1, c_s1;
	logic signed [PROD_W-1:0] bb_s1, ac_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= coef_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1  <= coef.coef_a;
			b_s1  <= coef.coef_b;
			c_s1  <= coef.coef_c;
			bb_s1 <= coef.coef_b * coef.coef_b;
			ac_s1 <= coef.coef_a * coef.coef_c;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: discriminant, classification, radicand
	// ------------------------------------------------------------------
	logic                     sq_valid_q [SQ_STEPS+1];
	sq_side_t                 sq_side_q  [SQ_STEPS+1];
	sq_state_t                sq_st_q    [SQ_STEPS+1];

	logic signed [DISC_W-1:0] disc;
	logic [DISC_W-1:0]        disc_neg;
	logic [DMAG_W-1:0]        disc_mag;
	kind_t                    kind_s1;

	always_comb begin
		disc     = DISC_W'(bb_s1) - (DISC_W'(ac_s1) <<< 2);
		disc_neg = -disc;
		disc_mag = disc[DISC_W-1] ? disc_neg[DMAG_W-1:0] : disc[DMAG_W-1:0];
		// a and b both zero has no root: report it as degenerate
		priority if (a_s1 == '0 && b_s1 == '0) begin
			kind_s1 = KIND_DEGENERATE;
		end else if (a_s1 == '0) begin
			kind_s1 = KIND_LINEAR;
		end else if (disc == '0) begin
			kind_s1 = KIND_EQUAL;
		end else if (!disc[DISC_W-1]) begin
			kind_s1 = KIND_DISTINCT;
		end else begin
			kind_s1 = KIND_COMPLEX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_valid_q[0] <= 1'b0;
		end else if (en) begin
			sq_valid_q[0] <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_side_q[0].kind <= kind_s1;
			sq_side_q[0].a    <= a_s1;
			sq_side_q[0].b    <= b_s1;
			sq_side_q[0].c    <= c_s1;
			// radicand |d| scaled by 2^(2*UP_SH), root bits start clear
			sq_st_q[0].rad    <= {disc_mag, {(RAD_W - DMAG_W){1'b0}}};
			sq_st_q[0].rem    <= '0;
			sq_st_q[0].root   <= '0;
		end
	end

	// ------------------------------------------------------------------
	// Square root chain: one root bit per cell
	// ------------------------------------------------------------------
	for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
		qrs_sqrt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.valid_in (sq_valid_q[i]),
			.side_in  (sq_side_q[i]),
			.st_in    (sq_st_q[i]),
			.valid_q  (sq_valid_q[i+1]),
			.side_q   (sq_side_q[i+1]),
			.st_q     (sq_st_q[i+1])
		);
	end

	// ------------------------------------------------------------------
	// Numerator stage: pick numerators and divisor per root kind
	// ------------------------------------------------------------------
	logic      dv_valid_q [NQ_W+1];
	dv_side_t  dv_side_q  [NQ_W+1];
	dv_pair_t  dv_pair_q  [NQ_W+1];

	sq_side_t              ns;
	logic signed [NUM_W-1:0] bx, cx, sx, nb8, num1, num2, neg1, neg2;
	logic signed [DEN_W:0] den, den_neg;
	logic [DEN_W-1:0]      den_mag;

	always_comb begin
		ns   = sq_side_q[SQ_STEPS];
		bx   = NUM_W'(ns.b);
		cx   = NUM_W'(ns.c);
		sx   = {{(NUM_W - ROOT_W){1'b0}}, sq_st_q[SQ_STEPS].root};
		nb8  = -(bx <<< UP_SH);
		unique case (ns.kind)
			KIND_LINEAR: begin
				num1 = -(cx <<< RFR);
				num2 = '0;
			end
			KIND_EQUAL: begin
				num1 = -(bx <<< RFR);
				num2 = num1;
			end
			KIND_DISTINCT: begin
				num1 = (nb8 + sx) <<< CFR;
				num2 = (nb8 - sx) <<< CFR;
			end
			KIND_COMPLEX: begin
				// imaginary part keeps the sign of a
				num1 = -(bx <<< RFR);
				num2 = sx <<< CFR;
			end
			default: begin
				num1 = '0;
				num2 = '0;
			end
		endcase
		neg1 = -num1;
		neg2 = -num2;

		if (ns.kind == KIND_LINEAR) begin
			den = (DEN_W + 1)'(ns.b);
		end else begin
			den = (DEN_W + 1)'(ns.a) <<< 1;
		end
		den_neg = -den;
		// degenerate numerators are zero; divide by one to keep them so
		if (ns.kind == KIND_DEGENERATE) begin
			den_mag = DEN_W'(1);
		end else begin
			den_mag = den[DEN_W] ? den_neg[DEN_W-1:0] : den[DEN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_valid_q[0] <= 1'b0;
		end else if (en) begin
			dv_valid_q[0] <= sq_valid_q[SQ_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_side_q[0].kind    <= ns.kind;
			dv_side_q[0].den_mag <= den_mag;
			dv_side_q[0].neg     <= {num2[NUM_W-1] ^ den[DEN_W],
			                         num1[NUM_W-1] ^ den[DEN_W]};
			dv_pair_q[0][0].rem  <= '0;
			dv_pair_q[0][0].nq   <= num1[NUM_W-1] ? neg1[NQ_W-1:0] : num1[NQ_W-1:0];
			dv_pair_q[0][1].rem  <= '0;
			dv_pair_q[0][1].nq   <= num2[NUM_W-1] ? neg2[NQ_W-1:0] : num2[NQ_W-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Divider chain: one quotient bit per cell, both lanes side by side
	// ------------------------------------------------------------------
	for (genvar j = 0; j < NQ_W; j++) begin : g_div
		qrs_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.valid_in (dv_valid_q[j]),
			.side_in  (dv_side_q[j]),
			.pair_in  (dv_pair_q[j]),
			.valid_q  (dv_valid_q[j+1]),
			.side_q   (dv_side_q[j+1]),
			.pair_q   (dv_pair_q[j+1])
		);
	end

	// Hold the whole pipeline while a blocked beat waits behind the output
	assign last_valid = dv_valid_q[NQ_W];
	assign en         = !(last_valid && root_valid && root_stall);
	assign coef_stall = !en;

	// ------------------------------------------------------------------
	// Output stage: restore sign, saturate, register the result beat
	// ------------------------------------------------------------------
	logic [RW-1:0] val [2];
	logic [1:0]    clip;

	always_comb begin
		logic [NQ_W-1:0] mag;
		logic [RW-1:0]   mneg;
		for (int k = 0; k < 2; k++) begin
			mag  = dv_pair_q[NQ_W][k].nq;
			mneg = -mag[RW-1:0];
			if (dv_side_q[NQ_W].neg[k]) begin
				clip[k] = (mag > NEG_LIM);
				val[k]  = clip[k] ? NEG_LIM[RW-1:0] : mneg;
			end else begin
				clip[k] = (mag > POS_LIM);
				val[k]  = clip[k] ? POS_LIM[RW-1:0] : mag[RW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_valid <= 1'b0;
		end else if (en && last_valid) begin
			root_valid <= 1'b1;
		end else if (!root_stall) begin
			root_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en && last_valid) begin
			root.root_kind    <= dv_side_q[NQ_W].kind;
			root.first_value  <= val[0];
			root.second_value <= val[1];
			root.clipped      <= |clip;
		end
	end

`ifndef SYNTHESIS
	a_degenerate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		root_valid && root.root_kind == KIND_DEGENERATE |->
		root.first_value == '0 && root.second_value == '0 && !root.clipped)
		else $error("degenerate result carries nonzero values");

	a_linear_second: assert property (@(posedge clk) disable iff (!arst_n)
		root_valid && root.root_kind == KIND_LINEAR |-> root.second_value == '0)
		else $error("linear result has nonzero second value");

	a_equal_roots: assert property (@(posedge clk) disable iff (!arst_n)
		root_valid && root.root_kind == KIND_EQUAL |->
		root.first_value == root.second_value)
		else $error("equal roots differ");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		coef_stall |-> root_valid && root_stall)
		else $error("input stalled without a blocked result beat");
`endif

endmodule

`default_nettype wire

@@ tb/tb_quadratic_root_solver.sv @@
// ----------------------------------------------------------------------------
// tb_quadratic_root_solver: self-checking bench for the quadratic root solver
// Drives coefficient beats through the valid/stall channel, predicts each root
// beat with an independent fixed-point solver and compares field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_quadratic_root_solver;
	timeunit 1ns;
	timeprecision 1ps;

	import qrs_pkg::*;

	localparam int LATENCY     = 63;
	localparam int CYCLE_LIMIT = 1000000;

	logic   clk;
	logic   arst_n;
	logic   coef_valid;
	logic   coef_stall;
	coef_t  coef;
	logic   root_valid;
	logic   root_stall;
	root_t  root;

	// Expected root beats, oldest first
	root_t  pending_roots[$];
	int     error_count;
	int     cycle_count;
	int     send_idle_pct;
	int     stall_pct;

	quadratic_root_solver uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.coef_valid(coef_valid),
		.coef_stall(coef_stall),
		.coef      (coef),
		.root_valid(root_valid),
		.root_stall(root_stall),
		.root      (root)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Floor square root of a wide unsigned value, bit by bit
	function automatic longint unsigned isqrt(input longint unsigned x);
		longint unsigned res;
		longint unsigned bitv;
		res  = 0;
		bitv = 64'd1 << 62;
		while (bitv > x)
			bitv >>= 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x   = x - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// Clamp a quotient to the signed root range, flagging any clamp
	function automatic logic signed [RW-1:0] clamp_root(input longint v, inout logic clip);
		longint hi;
		longint lo;
		hi = (longint'(1) << (RW - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin
			clip = 1'b1;
			return hi[RW-1:0];
		end
		if (v < lo) begin
			clip = 1'b1;
			return lo[RW-1:0];
		end
		return v[RW-1:0];
	endfunction

	// Solve one coefficient set the way the hardware must
	function automatic root_t solve_roots(input coef_t cf);
		root_t  r;
		longint a, b, c, disc, s, one_r, up, upc;
		logic   clip;
		a     = cf.coef_a;
		b     = cf.coef_b;
		c     = cf.coef_c;
		one_r = longint'(1) << RFR;
		up    = longint'(1) << UP_SH;
		upc   = longint'(1) << CFR;
		disc  = b * b - 4 * a * c;
		clip  = 1'b0;
		r.first_value  = '0;
		r.second_value = '0;
		if (a == 0) begin
			if (b == 0) begin
				r.root_kind = KIND_DEGENERATE;
			end else begin
				r.root_kind   = KIND_LINEAR;
				r.first_value = clamp_root((-c * one_r) / b, clip);
			end
		end else if (disc == 0) begin
			r.root_kind    = KIND_EQUAL;
			r.first_value  = clamp_root((-b * one_r) / (2 * a), clip);
			r.second_value = r.first_value;
		end else if (disc > 0) begin
			s = longint'(isqrt(longint'(disc) * (up * up)));
			r.root_kind    = KIND_DISTINCT;
			r.first_value  = clamp_root(((-b * up + s) * upc) / (2 * a), clip);
			r.second_value = clamp_root(((-b * up - s) * upc) / (2 * a), clip);
		end else begin
			s = longint'(isqrt(longint'(-disc) * (up * up)));
			r.root_kind    = KIND_COMPLEX;
			r.first_value  = clamp_root((-b * one_r) / (2 * a), clip);
			r.second_value = clamp_root((s * upc) / (2 * a), clip);
		end
		r.clipped = clip;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
		error_count++;
	endtask

	// Send one coefficient beat and hold it until taken
	task automatic send_coef(input coef_t cf);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			coef_valid <= 1'b0;
			@(posedge clk);
		end
		coef_valid <= 1'b1;
		coef       <= cf;
		pending_roots.push_back(solve_roots(cf));
		@(posedge clk);
		while (coef_stall)
			@(posedge clk);
	endtask

	task automatic send_abc(input int a, input int b, input int c);
		coef_t cf;
		cf.coef_a = a[CW-1:0];
		cf.coef_b = b[CW-1:0];
		cf.coef_c = c[CW-1:0];
		send_coef(cf);
	endtask

	// Check each root beat against the oldest prediction
	always @(posedge clk) begin
		root_t want;
		if (arst_n && root_valid && !root_stall) begin
			if (pending_roots.size() == 0) begin
				report_mismatch("unexpected root beat", 0, 0);
			end else begin
				want = pending_roots.pop_front();
				if (root.root_kind !== want.root_kind)
					report_mismatch("root_kind", root.root_kind, want.root_kind);
				if (root.first_value !== want.first_value)
					report_mismatch("first_value", root.first_value, want.first_value);
				if (root.second_value !== want.second_value)
					report_mismatch("second_value", root.second_value, want.second_value);
				if (root.clipped !== want.clipped)
					report_mismatch("clipped", root.clipped, want.clipped);
			end
		end
	end

	// Randomize sink stall on every edge
	always @(posedge clk) begin
		root_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
	end

	// End the run on a hung handshake
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout at cycle %0d", cycle_count);
			$display("FAILURE");
			$finish;
		end
	end

	// Directed corners: every kind, field extremes, large roots
	task automatic test_directed();
		send_abc(0, 0, 0);                 // degenerate
		send_abc(0, 0, -32768);            // degenerate, c ignored
		send_abc(0, 256, -512);            // linear
		send_abc(0, 1, 32767);             // linear, large root
		send_abc(0, -32768, -32768);       // linear, extremes
		send_abc(256, -512, 256);          // real equal
		send_abc(256, 0, -1024);           // real distinct
		send_abc(256, 0, 1024);            // complex
		send_abc(-256, 256, -1024);        // complex, negative a
		send_abc(1, 32767, 0);             // distinct, large root
		send_abc(1, 0, 32767);             // complex, large imaginary
		send_abc(-32768, -32768, -32768);
		send_abc(32767, 32767, 32767);
		send_abc(-32768, 32767, 32767);
		send_abc(32767, -32768, -32768);
		send_abc(-1, -1, -1);
		send_abc(1, 2, 1);                 // equal with tiny a
		send_abc(-32768, 0, 0);            // equal at zero
	endtask

	// Random coefficient sets, biased toward linear, small, equal-root and extreme-a cases
	task automatic test_random(input int count);
		int a, b, c, k;
		for (int i = 0; i < count; i++) begin
			k = $urandom_range(9);
			a = $signed(16'($urandom));
			b = $signed(16'($urandom));
			c = $signed(16'($urandom));
			unique case (k)
				0: begin
					a = 0;
				end
				1: begin
					a = $urandom_range(64) - 32;
					b = $urandom_range(64) - 32;
					c = $urandom_range(64) - 32;
					if (a == 0 && $urandom_range(1)) b = 0;
				end
				2: begin
					// b = 2*k*a, c = k*k*a gives a repeated root
					a = $urandom_range(20) - 10;
					k = $urandom_range(20) - 10;
					b = 2 * k * a;
					c = k * k * a;
				end
				3: begin
					a = $urandom_range(1) ? 32767 - $urandom_range(3)
					                      : -32768 + $urandom_range(3);
				end
				default: begin
				end
			endcase
			send_abc(a, b, c);
		end
	endtask

	task automatic drain();
		coef_valid <= 1'b0;
		while (pending_roots.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	initial begin
		arst_n        = 1'b0;
		coef_valid    = 1'b0;
		coef          = '0;
		send_idle_pct = 0;
		stall_pct     = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(400);
		send_idle_pct = 68;
		test_random(300);
		send_idle_pct = 0;
		stall_pct     = 68;
		test_random(300);
		send_idle_pct = 19;
		stall_pct     = 19;
		test_random(330);
		stall_pct     = 0;
		send_idle_pct = 0;
		drain();

		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire
